// ----- sv/dnhm_pkg.sv -----
// dnhm_pkg: shared constants and types for the dual nco heterodyne mixer
// no dependencies; used by dual_nco_heterodyne_mixer

package dnhm_pkg;

  localparam int TABLE_DEPTH_DEF = 512;

  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 9;
  localparam int VALUE_W  = 16;
  localparam int MIXED_W  = 32;
  localparam int CFG_W    = 10;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 32;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic [CFG_W-1:0] REF_LEN_RESET = CFG_W'(512);

  localparam logic signed [MIXED_W-1:0] MIXED_MAX = 32'sh7fff_ffff;
  localparam logic signed [MIXED_W-1:0] MIXED_MIN = 32'sh8000_0000;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TABLE  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    REG_REF_LEN  = 2'd0,
    REG_STEP_ONE = 2'd1,
    REG_STEP_TWO = 2'd2,
    REG_NONE     = 2'd3
  } reg_index_t;

endpackage

// ----- sv/dual_nco_heterodyne_mixer.sv -----
// dual_nco_heterodyne_mixer: table driven two oscillator mixer with saturating sum
// depends on dnhm_pkg; holds the reference table memory, phase counters and pipeline
//
// channel | role        | contents
// s_*     | item in     | tuser: req_type; tdata: sample, table_index, table_value
// m_*     | result out  | tdata: mixed
// apb     | config      | ref_len @0x0, step_one @0x4, step_two @0x8
//
// one item per cycle while the output is not stalled; a sample's result passes the table
// read registers at its transfer edge, then the product registers, then the sum and saturate
// output register; table writes give no result
// the two table read ports and the multiplier stage set the one cycle rate
// reset clears phases, registers and pipeline valids; the table is not cleared
// a stalled output only holds the stages behind it that are full

module dual_nco_heterodyne_mixer #(
  parameter int TABLE_DEPTH = dnhm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [15:0] sample, [24:16] table_index, [40:25] table_value, [47:41] zero
  input  logic [dnhm_pkg::S_TDATA_W-1:0]  s_tdata,
  // [0] req_type
  input  logic [0:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] mixed
  output logic [dnhm_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dnhm_pkg::APB_AW-1:0]     paddr,
  input  logic [dnhm_pkg::APB_DW-1:0]     pwdata,
  output logic [dnhm_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (LW > dnhm_pkg::CFG_W) ? LW : dnhm_pkg::CFG_W;
  localparam int AW = CW + 1;

  // input field split
  logic signed [dnhm_pkg::SAMPLE_W-1:0] in_sample;
  logic [dnhm_pkg::INDEX_W-1:0]         in_index;
  logic [dnhm_pkg::VALUE_W-1:0]         in_value;
  dnhm_pkg::req_type_t                  in_type;

  assign in_sample = s_tdata[15:0];
  assign in_index  = s_tdata[24:16];
  assign in_value  = s_tdata[40:25];
  assign in_type   = dnhm_pkg::req_type_t'(s_tuser[0]);

  // configuration registers
  logic [dnhm_pkg::CFG_W-1:0] ref_len;
  logic [dnhm_pkg::CFG_W-1:0] step_one;
  logic [dnhm_pkg::CFG_W-1:0] step_two;
  logic                       cfg_wr;
  dnhm_pkg::reg_index_t       cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = dnhm_pkg::reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_len  <= dnhm_pkg::REF_LEN_RESET;
      step_one <= '0;
      step_two <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        dnhm_pkg::REG_REF_LEN:  ref_len  <= pwdata[dnhm_pkg::CFG_W-1:0];
        dnhm_pkg::REG_STEP_ONE: step_one <= pwdata[dnhm_pkg::CFG_W-1:0];
        dnhm_pkg::REG_STEP_TWO: step_two <= pwdata[dnhm_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      dnhm_pkg::REG_REF_LEN:  prdata = dnhm_pkg::APB_DW'(ref_len);
      dnhm_pkg::REG_STEP_ONE: prdata = dnhm_pkg::APB_DW'(step_one);
      dnhm_pkg::REG_STEP_TWO: prdata = dnhm_pkg::APB_DW'(step_two);
      default:                prdata = '0;
    endcase
  end

  // effective table length: zero acts as one, clipped to the table depth
  logic [CW-1:0] len_ext;
  logic [CW-1:0] eff_len;

  assign len_ext = CW'(ref_len);

  always_comb begin
    if (len_ext == '0) begin
      eff_len = CW'(1);
    end else if (len_ext > CW'(TABLE_DEPTH)) begin
      eff_len = CW'(TABLE_DEPTH);
    end else begin
      eff_len = len_ext;
    end
  end

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                            input logic [dnhm_pkg::CFG_W-1:0] step,
                                            input logic [CW-1:0] n);
    logic [AW-1:0] s;
    logic [AW-1:0] q;
    begin
      s = (CW'(step) > n) ? AW'(n) : AW'(step);
      q = AW'(p) + s;
      if (q >= AW'(n)) begin
        q = q - AW'(n);
      end
      // a phase still at or above the length after one wrap restarts at zero
      if (q >= AW'(n)) begin
        q = '0;
      end
      advance = q[PW-1:0];
    end
  endfunction

  // pipeline handshake: each stage moves when the one after it has room
  logic v1, v2;
  logic e1, e2, e3;
  logic s_acc;
  logic smp_acc;
  logic tbl_acc;

  assign e3       = !m_tvalid || m_tready;
  assign e2       = !v2 || e3;
  assign e1       = !v1 || e2;
  assign s_tready = e1;
  assign s_acc    = s_tvalid && s_tready;
  assign smp_acc  = s_acc && (in_type == dnhm_pkg::REQ_SAMPLE);
  assign tbl_acc  = s_acc && (in_type == dnhm_pkg::REQ_TABLE);

  // phase counters advance on every accepted sample
  logic [PW-1:0] phase_one, phase_two;
  logic [PW-1:0] phase_one_next, phase_two_next;

  assign phase_one_next = advance(phase_one, step_one, eff_len);
  assign phase_two_next = advance(phase_two, step_two, eff_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_one <= '0;
      phase_two <= '0;
    end else if (smp_acc) begin
      phase_one <= phase_one_next;
      phase_two <= phase_two_next;
    end
  end

  // reference table: one write port, two registered read ports
  logic [dnhm_pkg::VALUE_W-1:0] ref_mem [TABLE_DEPTH];
  logic [dnhm_pkg::VALUE_W-1:0] rd_one, rd_two;
  logic                         idx_ok;

  assign idx_ok = CW'(in_index) < CW'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (tbl_acc && idx_ok) begin
      ref_mem[PW'(in_index)] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      rd_one <= ref_mem[phase_one];
      rd_two <= ref_mem[phase_two];
    end
  end

  // stage 1: sample beside the table read data
  logic signed [dnhm_pkg::SAMPLE_W-1:0] x1;
  logic                                 dual1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (e1) begin
      v1 <= smp_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      x1    <= in_sample;
      dual1 <= (step_two != '0);
    end
  end

  // stage 2: products
  logic signed [dnhm_pkg::MIXED_W-1:0] p1, p2;
  logic signed [dnhm_pkg::MIXED_W-1:0] prod_two;

  // signed product formed on its own so the select below cannot change its sign
  assign prod_two = x1 * $signed(rd_two);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (e2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (e2) begin
      p1 <= x1 * $signed(rd_one);
      p2 <= dual1 ? prod_two : '0;
    end
  end

  // stage 3: sum and saturate into the output register
  logic signed [dnhm_pkg::MIXED_W:0]   sum;
  logic signed [dnhm_pkg::MIXED_W-1:0] sat;

  assign sum = {p1[dnhm_pkg::MIXED_W-1], p1} + {p2[dnhm_pkg::MIXED_W-1], p2};

  always_comb begin
    if (sum[dnhm_pkg::MIXED_W] == sum[dnhm_pkg::MIXED_W-1]) begin
      sat = sum[dnhm_pkg::MIXED_W-1:0];
    end else if (sum[dnhm_pkg::MIXED_W]) begin
      sat = dnhm_pkg::MIXED_MIN;
    end else begin
      sat = dnhm_pkg::MIXED_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (e3) begin
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (e3) begin
      m_tdata <= sat;
    end
  end

  // checks
  a_sample_enters: assert property (@(posedge clk) disable iff (rst)
    smp_acc |=> v1)
    else $error("accepted sample did not reach stage 1");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    tbl_acc |=> !v1)
    else $error("table write produced a pipeline entry");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !smp_acc |=> $stable(phase_one) && $stable(phase_two))
    else $error("phase moved without a sample transfer");

  a_single_mix: assert property (@(posedge clk) disable iff (rst)
    e2 && v1 && !dual1 |=> p2 == '0)
    else $error("second product used with dual mix off");

  a_out_from_stage2: assert property (@(posedge clk) disable iff (rst)
    e3 && !v2 |=> !m_tvalid)
    else $error("result shown without a product stage entry");

endmodule
